>>> rtl/ukv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ukv_pkg: shared types for the unique key/value table
// Operation codes, result status codes and sequencer states.
// ----------------------------------------------------------------------------
package ukv_pkg;

   typedef enum logic [1:0] {
      OP_INSERT      = 2'd0,
      OP_REMOVE      = 2'd1,
      OP_READ        = 2'd2,
      OP_READ_CREATE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_APPENDED  = 3'd0,
      ST_REPLACED  = 3'd1,
      ST_REMOVED   = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_FOUND     = 3'd4,
      ST_CREATED   = 3'd5,
      ST_FULL      = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR
   } state_type;

endpackage
`default_nettype wire

>>> rtl/ukv_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ukv_store: single-port pair memory
// One read, one write or both per cycle; read data is registered.
// ----------------------------------------------------------------------------
module ukv_store #(
   parameter int DEPTH      = 16,
   parameter int DATA_BITS  = 64,
   parameter int ADDR_BITS  = 4
) (
   input  wire logic                 clock,
   input  wire logic                 rd_en,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] addr,
   input  wire logic [DATA_BITS-1:0] wr_data,
   output logic      [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> rtl/unique_key_value_table_core.sv
`default_nettype none
// Each entry scanned passes S_READ then S_CMP; a hit is answered from S_CMP, a miss from
// S_READ at the end; a remove shifts each later pair down, then answers from S_SHIFT_RD.
// One item at a time: busy drops as the strobe rises, and no new item is taken before;
// the single memory port is used for both scan and shift.
// Reset clears the state, index, entry count and strobe; the pair memory needs no clearing pass.
// The result strobe lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
// unique_key_value_table_core: linearly searched key/value table
// Sequencer that scans, updates and compacts pairs held in one memory.
// ----------------------------------------------------------------------------
module unique_key_value_table_core #(
   parameter int DEPTH      = 16,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [1:0]                       req_operation,
   input  wire logic [KEY_BITS-1:0]              req_key,
   input  wire logic [VALUE_BITS-1:0]            req_value,
   output logic                                  rsp_strobe,
   output logic [VALUE_BITS-1:0]                 rsp_read_value,
   output logic [2:0]                            rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]            rsp_entry_count
);
   import ukv_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DW = KEY_BITS + VALUE_BITS;

   state_type state_ff, state_in;
   op_type    op_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [CW-1:0]         rsp_count_ff, rsp_count_in;

   logic                  mem_rd, mem_wr;
   logic [AW-1:0]         mem_addr;
   logic [DW-1:0]         mem_wdata, mem_rdata;

   logic                  accept, hit, at_end, full, shift_more;
   logic [CW-1:0]         idx_plus;
   logic [KEY_BITS-1:0]   rd_key;
   logic [VALUE_BITS-1:0] rd_value;

   ukv_store #(
      .DEPTH     (DEPTH),
      .DATA_BITS (DW),
      .ADDR_BITS (AW)
   ) u_store (
      .clock   (clock),
      .rd_en   (mem_rd),
      .wr_en   (mem_wr),
      .addr    (mem_addr),
      .wr_data (mem_wdata),
      .rd_data (mem_rdata)
   );

   assign busy       = (state_ff != S_IDLE);
   assign accept     = start && !busy;
   assign rd_key     = mem_rdata[DW-1:VALUE_BITS];
   assign rd_value   = mem_rdata[VALUE_BITS-1:0];
   assign hit        = (rd_key == key_ff);
   assign at_end     = (idx_ff == count_ff);
   assign full       = (count_ff == CW'(DEPTH));
   assign idx_plus   = idx_ff + CW'(1);
   assign shift_more = (idx_plus < count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = at_end ? S_IDLE : S_CMP;
         end
         S_CMP: begin
            if (!hit) begin
               state_in = S_READ;
            end else if (op_ff == OP_REMOVE) begin
               state_in = S_SHIFT_RD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SHIFT_RD: begin
            state_in = shift_more ? S_SHIFT_WR : S_IDLE;
         end
         S_SHIFT_WR: begin
            state_in = S_SHIFT_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // memory control, counters and result
   always_comb begin
      idx_in        = idx_ff;
      count_in      = count_ff;
      mem_rd        = 1'b0;
      mem_wr        = 1'b0;
      mem_addr      = idx_ff[AW-1:0];
      mem_wdata     = {key_ff, value_ff};
      rsp_strobe_in = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               idx_in = '0;
            end
         end
         S_READ: begin
            if (!at_end) begin
               mem_rd = 1'b1;
            end else begin
               // miss: append or report
               rsp_strobe_in = 1'b1;
               rsp_value_in  = '0;
               case (op_ff)
                  OP_INSERT, OP_READ_CREATE: begin
                     if (full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        mem_wr   = 1'b1;
                        count_in = count_ff + CW'(1);
                        if (op_ff == OP_INSERT) begin
                           rsp_status_in = ST_APPENDED;
                           rsp_value_in  = value_ff;
                        end else begin
                           mem_wdata     = {key_ff, {VALUE_BITS{1'b0}}};
                           rsp_status_in = ST_CREATED;
                        end
                     end
                  end
                  default: begin
                     rsp_status_in = ST_NOT_FOUND;
                  end
               endcase
            end
         end
         S_CMP: begin
            if (!hit) begin
               idx_in = idx_plus;
            end else begin
               case (op_ff)
                  OP_INSERT: begin
                     mem_wr        = 1'b1;
                     rsp_strobe_in = 1'b1;
                     rsp_value_in  = value_ff;
                     rsp_status_in = ST_REPLACED;
                  end
                  OP_REMOVE: begin
                     // hold the removed value until compaction ends
                     rsp_value_in = rd_value;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_value_in  = rd_value;
                     rsp_status_in = ST_FOUND;
                  end
               endcase
            end
         end
         S_SHIFT_RD: begin
            if (shift_more) begin
               mem_rd   = 1'b1;
               mem_addr = idx_plus[AW-1:0];
            end else begin
               count_in      = count_ff - CW'(1);
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_REMOVED;
            end
         end
         S_SHIFT_WR: begin
            // move the later pair down one slot
            mem_wr    = 1'b1;
            mem_wdata = mem_rdata;
            idx_in    = idx_plus;
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
      rsp_count_in = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         idx_ff        <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= op_type'(req_operation);
         key_ff   <= req_key;
         value_ff <= req_value;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule
`default_nettype wire
